### rtl/core/dgrf_pkg.sv
`timescale 1ns / 1ps

package dgrf_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam int MAX_BYTES_DEF  = 2048;

   localparam int DATA_W   = 8;
   localparam int CONN_W   = 32;
   localparam int LENGTH_W = 12;

   // operation codes, bit one alone selects flush
   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam int OP_FLUSH_BIT = 1;

   typedef enum logic [2:0] {
      STATUS_TAKEN    = 3'd0,
      STATUS_COMMIT   = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_OVERSIZE = 3'd3,
      STATUS_BYTE     = 3'd4,
      STATUS_EMPTY    = 3'd5,
      STATUS_FLUSHED  = 3'd6
   } status_type;

   typedef enum logic {
      STATE_IDLE,
      STATE_POP
   } state_type;

   typedef struct packed {
      status_type          status;
      logic [DATA_W-1:0]   data;
      logic [CONN_W-1:0]   conn;
      logic                last;
      logic [LENGTH_W-1:0] length;
   } result_type;

endpackage

### rtl/core/dgrf_ram.sv
`timescale 1ns / 1ps

module dgrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/dgrf_ctrl.sv
`timescale 1ns / 1ps

module dgrf_ctrl
   import dgrf_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int MAX_BYTES  = MAX_BYTES_DEF,
   localparam int SLOT_W = $clog2(SLOT_COUNT),
   localparam int OFF_W  = $clog2(MAX_BYTES + 1),
   localparam int DEPTH  = SLOT_COUNT * MAX_BYTES,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int META_W = OFF_W + CONN_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [1:0]          in_op,
   input  logic [DATA_W-1:0]   in_data,
   input  logic [CONN_W-1:0]   in_conn,
   input  logic                in_last,
   input  logic                out_free,
   output logic                res_load,
   output result_type          res,
   output logic                byte_we,
   output logic [ADDR_W-1:0]   byte_waddr,
   output logic [DATA_W-1:0]   byte_wdata,
   output logic                byte_re,
   output logic [ADDR_W-1:0]   byte_raddr,
   input  logic [DATA_W-1:0]   byte_rdata,
   output logic                meta_we,
   output logic [SLOT_W-1:0]   meta_waddr,
   output logic [META_W-1:0]   meta_wdata,
   output logic                meta_re,
   output logic [SLOT_W-1:0]   meta_raddr,
   input  logic [META_W-1:0]   meta_rdata
);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [OFF_W-1:0]  fill_ff, fill_in;
   logic              oversize_ff, oversize_in;
   logic [OFF_W-1:0]  drain_ff, drain_in;

   logic              accept;
   logic              room;
   logic [SLOT_W-1:0] tail_next;
   logic [SLOT_W-1:0] head_next;
   logic [OFF_W-1:0]  drain_sel;
   logic [OFF_W-1:0]  rd_len;
   logic [OFF_W:0]    drain_inc;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i);
      next_slot = (i == SLOT_W'(SLOT_COUNT - 1)) ? '0 : SLOT_W'(i + 1'b1);
   endfunction

   assign tail_next = next_slot(tail_ff);
   assign head_next = next_slot(head_ff);
   assign room      = (fill_ff < OFF_W'(MAX_BYTES));
   assign drain_sel = (drain_ff >= OFF_W'(MAX_BYTES)) ? OFF_W'(MAX_BYTES - 1) : drain_ff;
   assign rd_len    = meta_rdata[OFF_W-1:0];
   assign drain_inc = {1'b0, drain_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= STATE_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         fill_ff     <= '0;
         oversize_ff <= 1'b0;
         drain_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         fill_ff     <= fill_in;
         oversize_ff <= oversize_in;
         drain_ff    <= drain_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      oversize_in = oversize_ff;
      drain_in    = drain_ff;
      in_ready    = 1'b0;
      accept      = 1'b0;
      res_load    = 1'b0;
      res         = '0;
      byte_we     = 1'b0;
      byte_waddr  = ADDR_W'(ADDR_W'(tail_ff) * ADDR_W'(MAX_BYTES) + ADDR_W'(fill_ff));
      byte_wdata  = in_data;
      byte_re     = 1'b0;
      byte_raddr  = ADDR_W'(ADDR_W'(head_ff) * ADDR_W'(MAX_BYTES) + ADDR_W'(drain_sel));
      meta_we     = 1'b0;
      meta_waddr  = tail_ff;
      meta_wdata  = {in_conn, OFF_W'(fill_ff + 1'b1)};
      meta_re     = 1'b0;
      meta_raddr  = head_ff;

      case (state_ff)
         STATE_IDLE: begin
            in_ready = out_free;
            accept   = in_valid && out_free;
            if (accept) begin
               if (in_op[OP_FLUSH_BIT]) begin
                  head_in     = '0;
                  tail_in     = '0;
                  fill_in     = '0;
                  oversize_in = 1'b0;
                  drain_in    = '0;
                  res.status  = STATUS_FLUSHED;
                  res_load    = 1'b1;
               end else if (in_op == OP_PUSH) begin
                  res_load = 1'b1;
                  if (room) begin
                     byte_we = 1'b1;
                     fill_in = OFF_W'(fill_ff + 1'b1);
                  end else begin
                     oversize_in = 1'b1;
                  end
                  if (in_last) begin
                     // oversize wins over full
                     if (oversize_ff || !room) begin
                        res.status = STATUS_OVERSIZE;
                     end else if (tail_next == head_ff) begin
                        res.status = STATUS_FULL;
                     end else begin
                        meta_we    = 1'b1;
                        tail_in    = tail_next;
                        res.status = STATUS_COMMIT;
                     end
                     fill_in     = '0;
                     oversize_in = 1'b0;
                  end else begin
                     res.status = STATUS_TAKEN;
                  end
               end else begin
                  if (head_ff == tail_ff) begin
                     res.status = STATUS_EMPTY;
                     res_load   = 1'b1;
                  end else begin
                     byte_re  = 1'b1;
                     meta_re  = 1'b1;
                     state_in = STATE_POP;
                  end
               end
            end
         end
         STATE_POP: begin
            // read data of the head slot is back
            res_load   = 1'b1;
            res.status = STATUS_BYTE;
            res.data   = byte_rdata;
            res.conn   = meta_rdata[META_W-1:OFF_W];
            res.length = LENGTH_W'(rd_len);
            if (drain_inc >= {1'b0, rd_len}) begin
               res.last = 1'b1;
               drain_in = '0;
               head_in  = head_next;
            end else begin
               drain_in = drain_inc[OFF_W-1:0];
            end
            state_in = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/datagram_ring_fifo.sv
`timescale 1ns / 1ps

// datagram ring fifo: a ring of SLOT_COUNT datagram slots of up to MAX_BYTES bytes each.
// req channel: tuser carries the operation (push, pop, flush), tlast marks the last pushed
// byte, tdata carries the byte and the connection id (kept from the last byte only).
// rsp channel: exactly one transfer per request, tuser carries the status, tlast marks
// the final byte of a popped datagram, tdata carries byte, connection id and length.
// push, flush and pop on an empty ring: the result is registered at the accepting edge
// and shows on the next cycle, so pushes run at one transfer per cycle unless rsp stalls.
// pop of a byte: the byte and slot-information memories are read at the accepting edge,
// the result is loaded from their read registers in POP, where no request is taken.
// one slot always stays free, so at most SLOT_COUNT-1 datagrams are held.
// reset clears head, tail, fill/drain offsets and flags; memory contents are left as they
// are and are never read before a commit has written them, so no clearing pass runs.
// when the receiver stalls the result waits in the output register; a new request is
// taken in the cycle that register is emptied or while it is empty.
module datagram_ring_fifo
   import dgrf_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int MAX_BYTES  = MAX_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte[7:0], conn_id[39:8]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // out_byte[7:0], out_conn_id[39:8], out_length[51:40]
   output logic [2:0]  rsp_tuser,   // status[2:0]
   output logic        rsp_tlast
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int OFF_W  = $clog2(MAX_BYTES + 1);
   localparam int DEPTH  = SLOT_COUNT * MAX_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int META_W = OFF_W + CONN_W;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;
   logic              out_free;
   logic              res_load;
   result_type        res;

   logic              byte_we, byte_re;
   logic [ADDR_W-1:0] byte_waddr, byte_raddr;
   logic [DATA_W-1:0] byte_wdata, byte_rdata;
   logic              meta_we, meta_re;
   logic [SLOT_W-1:0] meta_waddr, meta_raddr;
   logic [META_W-1:0] meta_wdata, meta_rdata;

   assign out_free = !rsp_valid_ff || rsp_tready;

   dgrf_ctrl #(
      .SLOT_COUNT (SLOT_COUNT),
      .MAX_BYTES  (MAX_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_op      (req_tuser),
      .in_data    (req_tdata[7:0]),
      .in_conn    (req_tdata[39:8]),
      .in_last    (req_tlast),
      .out_free   (out_free),
      .res_load   (res_load),
      .res        (res),
      .byte_we    (byte_we),
      .byte_waddr (byte_waddr),
      .byte_wdata (byte_wdata),
      .byte_re    (byte_re),
      .byte_raddr (byte_raddr),
      .byte_rdata (byte_rdata),
      .meta_we    (meta_we),
      .meta_waddr (meta_waddr),
      .meta_wdata (meta_wdata),
      .meta_re    (meta_re),
      .meta_raddr (meta_raddr),
      .meta_rdata (meta_rdata)
   );

   dgrf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (byte_waddr),
      .wr_data (byte_wdata),
      .rd_en   (byte_re),
      .rd_addr (byte_raddr),
      .rd_data (byte_rdata)
   );

   // slot information: connection id above length
   dgrf_ram #(
      .WIDTH (META_W),
      .DEPTH (SLOT_COUNT)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (meta_re),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {4'b0000, rsp_ff.length, rsp_ff.conn, rsp_ff.data};

endmodule

### tb/sv/datagram_ring_fifo_tb.sv
`timescale 1ns / 1ps

module datagram_ring_fifo_tb
   import dgrf_pkg::*;
;

   localparam int RING_SLOTS = SLOT_COUNT_DEF;
   localparam int SLOT_BYTES = MAX_BYTES_DEF;
   localparam int RANDOM_ITEMS = 700;

   // flush is decoded from bit one alone
   localparam logic [1:0] OP_FLUSH     = 2'd2;
   localparam logic [1:0] OP_FLUSH_ALT = 2'd3;

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  data;
      logic [31:0] conn;
      logic        last;
   } dgram_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // data_byte[7:0], conn_id[39:8]
   logic [1:0]  req_tuser = '0;   // operation[1:0]
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // out_byte[7:0], out_conn_id[39:8], out_length[51:40]
   logic [2:0]  rsp_tuser;        // status[2:0]
   logic        rsp_tlast;

   dgram_req_type queued_ops[$];
   result_type    due_results[$];
   int unsigned predicted_count = 0;
   int unsigned received_count = 0;
   int unsigned stim_count = 0;
   int unsigned error_count = 0;
   logic        long_hold_req = 1'b0;

   // shadow of the ring
   logic [7:0]  ring_bytes [RING_SLOTS*SLOT_BYTES];
   int unsigned ring_len [RING_SLOTS];
   logic [31:0] ring_conn [RING_SLOTS];
   int unsigned head_idx = 0;
   int unsigned tail_idx = 0;
   int unsigned fill_off = 0;
   int unsigned drain_off = 0;
   bit          fill_over = 1'b0;

   datagram_ring_fifo dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic result_type datagram_step(input dgram_req_type r);
      result_type  res;
      int unsigned t;
      int unsigned h;
      res = '0;
      if (r.op[OP_FLUSH_BIT]) begin
         head_idx  = 0;
         tail_idx  = 0;
         fill_off  = 0;
         fill_over = 1'b0;
         drain_off = 0;
         res.status = STATUS_FLUSHED;
      end else if (r.op == OP_PUSH) begin
         t = tail_idx;
         if (fill_off < SLOT_BYTES) begin
            ring_bytes[t*SLOT_BYTES + fill_off] = r.data;
            fill_off++;
         end else begin
            fill_over = 1'b1;
         end
         if (r.last) begin
            // oversize wins over full
            if (fill_over) begin
               res.status = STATUS_OVERSIZE;
            end else if ((t + 1) % RING_SLOTS == head_idx) begin
               res.status = STATUS_FULL;
            end else begin
               ring_len[t]  = fill_off;
               ring_conn[t] = r.conn;
               tail_idx     = (t + 1) % RING_SLOTS;
               res.status   = STATUS_COMMIT;
            end
            fill_off  = 0;
            fill_over = 1'b0;
         end else begin
            res.status = STATUS_TAKEN;
         end
      end else begin
         if (head_idx == tail_idx) begin
            res.status = STATUS_EMPTY;
         end else begin
            h          = head_idx;
            res.data   = ring_bytes[h*SLOT_BYTES + drain_off];
            res.conn   = ring_conn[h];
            res.length = LENGTH_W'(ring_len[h]);
            if (drain_off + 1 >= ring_len[h]) begin
               res.last  = 1'b1;
               drain_off = 0;
               head_idx  = (h + 1) % RING_SLOTS;
            end else begin
               drain_off++;
            end
            res.status = STATUS_BYTE;
         end
      end
      return res;
   endfunction

   task automatic add_op(input logic [1:0] op, input logic [7:0] data,
                         input logic [31:0] conn, input logic last);
      dgram_req_type r;
      r.op   = op;
      r.data = data;
      r.conn = conn;
      r.last = last;
      queued_ops.push_back(r);
      stim_count++;
   endtask

   task automatic add_datagram(input int unsigned len, input logic [31:0] conn);
      for (int unsigned i = 0; i < len; i++) begin
         if (i == len - 1)
            add_op(OP_PUSH, 8'($urandom), conn, 1'b1);
         else
            add_op(OP_PUSH, 8'($urandom), $urandom, 1'b0);
      end
   endtask

   task automatic add_pops(input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         add_op(OP_POP, 8'($urandom), $urandom, 1'($urandom));
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (queued_ops.size() != 0 || req_tvalid || due_results.size() != 0);
   endtask

   always @(posedge clock) begin : driver_proc
      dgram_req_type on_wire;
      int unsigned   burst_left;
      int unsigned   gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         req_tlast  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_results.push_back(datagram_step(on_wire));
            predicted_count <= predicted_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (queued_ops.size() > 0) begin
               on_wire = queued_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {on_wire.conn, on_wire.data};
               req_tuser  <= on_wire.op;
               req_tlast  <= on_wire.last;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : receiver_proc
      logic [31:0] cyc;
      int unsigned hold_left;
      bit          long_hold_done;
      if (reset) begin
         rsp_tready <= 1'b0;
         cyc            = '0;
         hold_left      = 0;
         long_hold_done = 1'b0;
      end else begin
         cyc++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_req && !long_hold_done) begin
            // long back-pressure so the input side stalls too
            long_hold_done = 1'b1;
            hold_left      = 150;
            rsp_tready <= 1'b0;
         end else begin
            case (cyc[8:7])
               2'd0: rsp_tready <= 1'b1;
               2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2'd2: rsp_tready <= (cyc[2:0] != 3'd5);
               default: rsp_tready <= ($urandom_range(0, 1) == 1);
            endcase
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor_proc
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         received_count <= received_count + 1;
         // counters hold their pre-edge values, so a prediction made at this edge is not seen
         if (received_count >= predicted_count || due_results.size() == 0) begin
            $error("unexpected transfer: status %0d", rsp_tuser);
            error_count++;
         end else begin
            want = due_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_tuser));
            check_field("out_byte", 32'(want.data), 32'(rsp_tdata[7:0]));
            check_field("out_conn_id", want.conn, rsp_tdata[39:8]);
            check_field("out_last", 32'(want.last), 32'(rsp_tlast));
            check_field("out_length", 32'(want.length), 32'(rsp_tdata[51:40]));
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin : stimulus_proc
      int unsigned random_end;
      int unsigned sel;
      int unsigned push_weight;

      // short directed run
      add_pops(1);
      add_op(OP_PUSH, 8'h00, 32'h0000_0000, 1'b1);
      add_op(OP_PUSH, 8'hFF, 32'h0000_0000, 1'b0);
      add_op(OP_PUSH, 8'h5A, 32'hA5A5_A5A5, 1'b0);
      add_op(OP_PUSH, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      add_pops(5);
      // flush in the middle of a push
      add_datagram(3, 32'h1234_5678);
      add_op(OP_PUSH, 8'h11, 32'h0, 1'b0);
      add_op(OP_FLUSH, 8'h00, 32'h0, 1'b0);
      add_pops(1);
      // flush in the middle of a pop, using the alternate code
      add_datagram(2, 32'h8000_0001);
      add_pops(1);
      add_op(OP_FLUSH_ALT, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      add_pops(1);
      wait_drained();

      // fill the ring, then oversize while full, then a plain full drop
      for (int i = 0; i < RING_SLOTS - 1; i++)
         add_datagram($urandom_range(1, 2), $urandom);
      add_datagram(SLOT_BYTES + 1, $urandom);
      add_datagram(1, $urandom);
      add_pops(2 * (RING_SLOTS - 1) + 1);
      // largest datagram that fits
      add_datagram(SLOT_BYTES, $urandom);
      add_pops(SLOT_BYTES + 1);
      wait_drained();

      // random sequences, push-heavy and pop-heavy stretches in turn
      random_end = stim_count + RANDOM_ITEMS;
      long_hold_req = 1'b0;
      while (stim_count < random_end) begin
         push_weight = ((stim_count / 120) % 2 == 0) ? 7 : 3;
         sel = $urandom_range(0, 9);
         if (sel < push_weight) begin
            add_datagram(($urandom_range(0, 15) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(1, 8), $urandom);
         end else if (sel < 9) begin
            add_pops($urandom_range(1, 16));
         end else if ($urandom_range(0, 2) == 0) begin
            add_op(2'($urandom_range(0, 3)), 8'($urandom), $urandom, 1'($urandom));
         end else begin
            if ($urandom_range(0, 1) == 1)
               add_datagram($urandom_range(1, 4), $urandom);
            for (int unsigned i = $urandom_range(1, 4); i > 0; i--)
               add_op(OP_PUSH, 8'($urandom), $urandom, 1'b0);
            add_pops($urandom_range(0, 3));
            add_op(($urandom_range(0, 1) == 1) ? OP_FLUSH_ALT : OP_FLUSH,
                   8'($urandom), $urandom, 1'($urandom));
         end
      end
      repeat (40) @(negedge clock);
      long_hold_req = 1'b1;
      wait_drained();

      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #25_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
